// File: rtl/esa_pkg.sv
// ----------------------------------------------------------------------------
// esa_pkg
// shared types and constants of the error statistics accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package esa_pkg;

  localparam int unsigned Channels = 16;
  localparam int unsigned ChW      = 4;
  localparam int unsigned ChIdxW   = (Channels > 1) ? $clog2(Channels) : 1;

  localparam logic [30:0] Max31 = 31'h7fff_ffff;

  // configuration register indexes
  typedef enum logic [0:0] {
    RegAbsLimit = 1'b0,
    RegRelLimit = 1'b1
  } reg_idx_e;

  // divider operand selection
  typedef enum logic [2:0] {
    DivRel    = 3'd0,
    DivAbsAvg = 3'd1,
    DivRelAvg = 3'd2,
    DivAbsVar = 3'd3,
    DivRelVar = 3'd4
  } div_sel_e;

  // controller -> datapath commands
  typedef struct packed {
    logic     load;       // capture input word, form differences
    logic     div_start;  // launch divider
    div_sel_e div_sel;
    logic     rel_fin;    // store relative quotient, compute flags
    logic     abs_upd;    // apply abs welford update after mean division
    logic     rel_upd;
    logic     abs_var;    // store abs variance quotient
    logic     rel_var;
    logic     wr_back;    // write statistics back to channel tables
    logic     out_load;   // load result register
  } esa_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic div_done;
    logic rel_valid;
    logic ch_ok;
    logic abs_two;   // abs count >= 2 after update
    logic rel_two;
  } esa_sts_t;

  typedef struct packed {
    logic [ChW-1:0] channel;
    logic [31:0]    model_value;
    logic [31:0]    expected_value;
  } esa_in_t;

  typedef struct packed {
    logic [30:0] abs_difference;
    logic [30:0] rel_difference;
    logic        rel_valid;
    logic        abs_over;
    logic        rel_over;
    logic        mismatch_seen;
    logic [30:0] abs_peak_out;
    logic [30:0] abs_avg_out;
    logic [30:0] abs_spread_out;
    logic [30:0] rel_peak_out;
    logic [30:0] rel_avg_out;
    logic [30:0] rel_spread_out;
  } esa_out_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [31:0] data;
  } esa_cfg_t;

endpackage

`default_nettype wire

// File: rtl/esa_if.sv
// ----------------------------------------------------------------------------
// esa_if
// valid/ready channel interfaces for input, result and configuration words
// ----------------------------------------------------------------------------
`default_nettype none

interface esa_in_if;
  import esa_pkg::*;
  logic    valid;
  logic    ready;
  esa_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface esa_out_if;
  import esa_pkg::*;
  logic     valid;
  logic     ready;
  esa_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface esa_cfg_if;
  import esa_pkg::*;
  logic     valid;
  logic     ready;
  esa_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/error_statistics_accumulator.sv
// ----------------------------------------------------------------------------
// error_statistics_accumulator
// per-channel absolute/relative error check with running welford statistics
// ----------------------------------------------------------------------------
//  channel   dir  word contents
//  in_ch     in   channel, model_value, expected_value
//  out_ch    out  differences, flags, peak/mean/variance of both kinds
//  cfg_ch    in   register index (0 abs_limit, 1 rel_limit), write data
//
//  one word runs 1 to 5 divisions on the bit-serial divider between one accept
//  and the next; the divider sets how fast words are taken
//  reset clears limits, sticky flag and all channel statistics at once
//  the next word is taken while the previous result still waits on out_ch
//  a stalled out_ch holds the sequencer only at the final write-back step
// ----------------------------------------------------------------------------
`default_nettype none

module error_statistics_accumulator (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  esa_in_if.sink     in_ch,
  esa_out_if.source  out_ch,
  esa_cfg_if.sink    cfg_ch
);
  import esa_pkg::*;

  esa_cmd_t cmd;
  esa_sts_t sts;

  // configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  esa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  esa_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .in_i     (in_ch.data),
    .cfg_we_i (cfg_ch.valid),
    .cfg_i    (cfg_ch.data),
    .out_o    (out_ch.data)
  );

endmodule

`default_nettype wire

// File: rtl/esa_div.sv
// ----------------------------------------------------------------------------
// esa_div
// restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module esa_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);
  import esa_pkg::*;

  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_q[31:0], quo_q[63]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_d = diff;
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  property p_no_start_busy;
    @(posedge clk_i) disable iff (!rst_ni) busy_q |-> !start_i;
  endproperty
  a_no_start_busy: assert property (p_no_start_busy) else $error("divider restarted");

  property p_done_ends_busy;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q;
  endproperty
  a_done_ends_busy: assert property (p_done_ends_busy) else $error("done while busy");

  property p_done_pulse;
    @(posedge clk_i) disable iff (!rst_ni) done_q |=> !done_q;
  endproperty
  a_done_pulse: assert property (p_done_pulse) else $error("done held");

endmodule

`default_nettype wire

// File: rtl/esa_datapath.sv
// ----------------------------------------------------------------------------
// esa_datapath
// differences, thresholds, welford state tables and the shared divider
// ----------------------------------------------------------------------------
`default_nettype none

module esa_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  esa_pkg::esa_cmd_t cmd_i,
  output esa_pkg::esa_sts_t sts_o,
  input  esa_pkg::esa_in_t  in_i,
  input  logic              cfg_we_i,
  input  esa_pkg::esa_cfg_t cfg_i,
  output esa_pkg::esa_out_t out_o
);
  import esa_pkg::*;

  // per-channel state, reset clears all entries
  logic [31:0] abs_cnt_q [Channels];
  logic [30:0] abs_pk_q  [Channels];
  logic [30:0] abs_av_q  [Channels];
  logic [63:0] abs_sq_q  [Channels];
  logic [31:0] rel_cnt_q [Channels];
  logic [30:0] rel_pk_q  [Channels];
  logic [30:0] rel_av_q  [Channels];
  logic [63:0] rel_sq_q  [Channels];

  logic [30:0] abs_lim_q, rel_lim_q;
  logic        mis_q;

  logic [ChW-1:0] ch_q;
  logic [ChIdxW-1:0] idx;
  logic        ch_ok_q;
  logic [30:0] absd_q, reld_q;
  logic [31:0] emag_q;
  logic        rv_q, aover_q, rover_q;

  // working copies of the channel statistics
  logic [31:0] a_cnt_q, r_cnt_q;
  logic [30:0] a_pk_q, a_av_q, r_pk_q, r_av_q;
  logic [63:0] a_sq_q, r_sq_q;
  logic [30:0] a_var_q, r_var_q;
  logic        a_ge_q, r_ge_q;
  logic [30:0] a_dold_q, r_dold_q;

  logic [63:0] div_num;
  logic [31:0] div_den;
  logic        div_done;
  logic [63:0] div_q;

  logic [32:0] diff;
  logic [31:0] dmag;
  logic [30:0] absd;
  logic [31:0] emag;

  assign idx = ch_q[ChIdxW-1:0];

  always_comb begin
    diff = {in_i.model_value[31], in_i.model_value}
         - {in_i.expected_value[31], in_i.expected_value};
    dmag = diff[32] ? 32'(-diff) : diff[31:0];
    absd = (dmag > {1'b0, Max31}) ? Max31 : dmag[30:0];
    emag = in_i.expected_value[31] ? 32'(-in_i.expected_value) : in_i.expected_value;
  end

  // welford helpers: direction flag, old mean, divider quotient
  function automatic logic [30:0] f_newavg(logic ge, logic [30:0] av, logic [63:0] q);
    logic [30:0] s;
    s = q[30:0];
    f_newavg = ge ? 31'(av + s) : 31'(av - s);
  endfunction

  function automatic logic [63:0] f_sqadd(logic [63:0] sq, logic [63:0] p);
    logic [64:0] t;
    t = {1'b0, sq} + {1'b0, p};
    f_sqadd = t[64] ? {64{1'b1}} : t[63:0];
  endfunction

  function automatic logic [30:0] f_var(logic [63:0] q);
    logic [47:0] v;
    v = q[63:16];
    f_var = (v > {17'd0, Max31}) ? Max31 : v[30:0];
  endfunction

  always_comb begin
    div_num = '0;
    div_den = 32'd1;
    case (cmd_i.div_sel)
      DivRel: begin
        div_num = {17'd0, absd_q, 16'd0};
        div_den = emag_q;
      end
      DivAbsAvg: begin
        div_num = {33'd0, a_dold_q};
        div_den = a_cnt_q;
      end
      DivRelAvg: begin
        div_num = {33'd0, r_dold_q};
        div_den = r_cnt_q;
      end
      DivAbsVar: begin
        div_num = a_sq_q;
        div_den = 32'(a_cnt_q - 32'd1);
      end
      DivRelVar: begin
        div_num = r_sq_q;
        div_den = 32'(r_cnt_q - 32'd1);
      end
      default: ;
    endcase
  end

  esa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // multiplier inputs for the squared-deviation term
  logic [30:0] a_nav, r_nav, a_dnew, r_dnew;
  logic [30:0] rel_sample;
  logic [61:0] a_prod, r_prod;

  always_comb begin
    a_nav  = f_newavg(a_ge_q, a_av_q, div_q);
    a_dnew = a_ge_q ? 31'(absd_q - a_nav) : 31'(a_nav - absd_q);
    a_prod = a_dold_q * a_dnew;
    r_nav  = f_newavg(r_ge_q, r_av_q, div_q);
    r_dnew = r_ge_q ? 31'(reld_q - r_nav) : 31'(r_nav - reld_q);
    r_prod = r_dold_q * r_dnew;
    rel_sample = (div_q > {33'd0, Max31}) ? Max31 : div_q[30:0];
  end

  // configuration and sticky flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_lim_q <= '0;
      rel_lim_q <= '0;
      mis_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_i.index))
          RegAbsLimit: abs_lim_q <= cfg_i.data[30:0];
          RegRelLimit: rel_lim_q <= cfg_i.data[30:0];
          default: ;
        endcase
      end
      if (cmd_i.rel_fin && (aover_q || (rv_q && (rel_sample > rel_lim_q))))
        mis_q <= 1'b1;
    end
  end

  // channel tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) begin
        abs_cnt_q[i] <= '0; abs_pk_q[i] <= '0; abs_av_q[i] <= '0; abs_sq_q[i] <= '0;
        rel_cnt_q[i] <= '0; rel_pk_q[i] <= '0; rel_av_q[i] <= '0; rel_sq_q[i] <= '0;
      end
    end else if (cmd_i.wr_back && ch_ok_q) begin
      abs_cnt_q[idx] <= a_cnt_q; abs_pk_q[idx] <= a_pk_q;
      abs_av_q[idx]  <= a_av_q;  abs_sq_q[idx] <= a_sq_q;
      rel_cnt_q[idx] <= r_cnt_q; rel_pk_q[idx] <= r_pk_q;
      rel_av_q[idx]  <= r_av_q;  rel_sq_q[idx] <= r_sq_q;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q    <= in_i.channel;
      ch_ok_q <= (32'(in_i.channel) < Channels);
      absd_q  <= absd;
      emag_q  <= emag;
      rv_q    <= (in_i.expected_value != 32'd0);
      aover_q <= (absd > abs_lim_q);
      rover_q <= 1'b0;
      reld_q  <= '0;
      a_var_q <= '0;
      r_var_q <= '0;
    end
    if (cmd_i.rel_fin) begin
      // latch stats of this channel and prepare both welford steps
      a_cnt_q  <= (abs_cnt_q[idx] == 32'hffff_ffff) ? abs_cnt_q[idx]
                                                    : 32'(abs_cnt_q[idx] + 32'd1);
      a_pk_q   <= (absd_q > abs_pk_q[idx]) ? absd_q : abs_pk_q[idx];
      a_av_q   <= abs_av_q[idx];
      a_sq_q   <= abs_sq_q[idx];
      a_ge_q   <= (absd_q >= abs_av_q[idx]);
      a_dold_q <= (absd_q >= abs_av_q[idx]) ? 31'(absd_q - abs_av_q[idx])
                                            : 31'(abs_av_q[idx] - absd_q);
      r_cnt_q  <= rel_cnt_q[idx];
      r_pk_q   <= rel_pk_q[idx];
      r_av_q   <= rel_av_q[idx];
      r_sq_q   <= rel_sq_q[idx];
      if (rv_q) begin
        reld_q   <= rel_sample;
        rover_q  <= (rel_sample > rel_lim_q);
        r_cnt_q  <= (rel_cnt_q[idx] == 32'hffff_ffff) ? rel_cnt_q[idx]
                                                      : 32'(rel_cnt_q[idx] + 32'd1);
        r_pk_q   <= (rel_sample > rel_pk_q[idx]) ? rel_sample : rel_pk_q[idx];
        r_ge_q   <= (rel_sample >= rel_av_q[idx]);
        r_dold_q <= (rel_sample >= rel_av_q[idx]) ? 31'(rel_sample - rel_av_q[idx])
                                                  : 31'(rel_av_q[idx] - rel_sample);
      end
    end
    if (cmd_i.abs_upd) begin
      a_av_q <= a_nav;
      a_sq_q <= f_sqadd(a_sq_q, {2'd0, a_prod});
    end
    if (cmd_i.rel_upd) begin
      r_av_q <= r_nav;
      r_sq_q <= f_sqadd(r_sq_q, {2'd0, r_prod});
    end
    if (cmd_i.abs_var) a_var_q <= f_var(div_q);
    if (cmd_i.rel_var) r_var_q <= f_var(div_q);
    if (cmd_i.out_load) begin
      out_o.abs_difference <= absd_q;
      out_o.rel_difference <= reld_q;
      out_o.rel_valid      <= rv_q;
      out_o.abs_over       <= aover_q;
      out_o.rel_over       <= rover_q;
      out_o.mismatch_seen  <= mis_q;
      out_o.abs_peak_out   <= ch_ok_q ? a_pk_q : '0;
      out_o.abs_avg_out    <= ch_ok_q ? a_av_q : '0;
      out_o.abs_spread_out <= ch_ok_q ? a_var_q : '0;
      out_o.rel_peak_out   <= ch_ok_q ? r_pk_q : '0;
      out_o.rel_avg_out    <= ch_ok_q ? r_av_q : '0;
      out_o.rel_spread_out <= ch_ok_q ? r_var_q : '0;
    end
  end

  always_comb begin
    sts_o.div_done  = div_done;
    sts_o.rel_valid = rv_q;
    sts_o.ch_ok     = ch_ok_q;
    sts_o.abs_two   = (a_cnt_q >= 32'd2);
    sts_o.rel_two   = (r_cnt_q >= 32'd2);
  end

  property p_sticky;
    @(posedge clk_i) disable iff (!rst_ni) mis_q |=> mis_q;
  endproperty
  a_sticky: assert property (p_sticky) else $error("mismatch flag cleared");

  property p_over_sets_flag;
    @(posedge clk_i) disable iff (!rst_ni) (cmd_i.rel_fin && aover_q) |=> mis_q;
  endproperty
  a_over_sets_flag: assert property (p_over_sets_flag) else $error("flag not set");

  property p_rel_zero;
    @(posedge clk_i) disable iff (!rst_ni) (cmd_i.out_load && !rv_q) |=> !out_o.rel_over;
  endproperty
  a_rel_zero: assert property (p_rel_zero) else $error("rel_over without valid");

endmodule

`default_nettype wire

// File: rtl/esa_ctrl.sv
// ----------------------------------------------------------------------------
// esa_ctrl
// sequencer for one sample: relative divide, abs and rel mean divides, abs and
// rel variance divides (all but the abs mean divide only when needed),
// write-back, result hand-off
`default_nettype none

module esa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output esa_pkg::esa_cmd_t cmd_o,
  input  esa_pkg::esa_sts_t sts_i
);
  import esa_pkg::*;

  typedef enum logic [11:0] {
    SIdle   = 12'b0000_0000_0001,
    SRelGo  = 12'b0000_0000_0010,
    SRelWt  = 12'b0000_0000_0100,
    SAbsGo  = 12'b0000_0000_1000,
    SAbsWt  = 12'b0000_0001_0000,
    SRmGo   = 12'b0000_0010_0000,
    SRmWt   = 12'b0000_0100_0000,
    SAvGo   = 12'b0000_1000_0000,
    SAvWt   = 12'b0001_0000_0000,
    SRvGo   = 12'b0010_0000_0000,
    SRvWt   = 12'b0100_0000_0000,
    SDone   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;
  logic   accept;

  assign accept     = in_valid_i && in_ready_o;
  // a new word may start while the last result still waits
  assign in_ready_o = (state_q == SIdle);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o   = '0;
    cmd_o.div_sel = DivRel;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = SRelGo;
        end
      end
      SRelGo: begin
        cmd_o.div_start = sts_i.rel_valid;
        state_d = sts_i.rel_valid ? SRelWt : SAbsGo;
        if (!sts_i.rel_valid) cmd_o.rel_fin = 1'b1;
      end
      SRelWt: begin
        if (sts_i.div_done) begin
          cmd_o.rel_fin = 1'b1;
          state_d = SAbsGo;
        end
      end
      SAbsGo: begin
        cmd_o.div_sel = DivAbsAvg;
        cmd_o.div_start = 1'b1;
        state_d = SAbsWt;
      end
      SAbsWt: begin
        cmd_o.div_sel = DivAbsAvg;
        if (sts_i.div_done) begin
          cmd_o.abs_upd = 1'b1;
          state_d = SRmGo;
        end
      end
      SRmGo: begin
        cmd_o.div_sel = DivRelAvg;
        cmd_o.div_start = sts_i.rel_valid;
        state_d = sts_i.rel_valid ? SRmWt : SAvGo;
      end
      SRmWt: begin
        cmd_o.div_sel = DivRelAvg;
        if (sts_i.div_done) begin
          cmd_o.rel_upd = 1'b1;
          state_d = SAvGo;
        end
      end
      SAvGo: begin
        cmd_o.div_sel = DivAbsVar;
        cmd_o.div_start = sts_i.abs_two;
        state_d = sts_i.abs_two ? SAvWt : SRvGo;
      end
      SAvWt: begin
        cmd_o.div_sel = DivAbsVar;
        if (sts_i.div_done) begin
          cmd_o.abs_var = 1'b1;
          state_d = SRvGo;
        end
      end
      SRvGo: begin
        cmd_o.div_sel = DivRelVar;
        cmd_o.div_start = sts_i.rel_two;
        state_d = sts_i.rel_two ? SRvWt : SDone;
      end
      SRvWt: begin
        cmd_o.div_sel = DivRelVar;
        if (sts_i.div_done) begin
          cmd_o.rel_var = 1'b1;
          state_d = SDone;
        end
      end
      SDone: begin
        // wait until the result register is free
        if (!ov_q || out_ready_i) begin
          cmd_o.wr_back  = 1'b1;
          cmd_o.out_load = 1'b1;
          ov_d    = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  property p_accept_idle;
    @(posedge clk_i) disable iff (!rst_ni) accept |=> (state_q == SRelGo);
  endproperty
  a_accept_idle: assert property (p_accept_idle) else $error("accept lost");

  property p_load_free;
    @(posedge clk_i) disable iff (!rst_ni) cmd_o.out_load |-> (!ov_q || out_ready_i);
  endproperty
  a_load_free: assert property (p_load_free) else $error("result overwritten");

  property p_done_valid;
    @(posedge clk_i) disable iff (!rst_ni) cmd_o.out_load |=> ov_q;
  endproperty
  a_done_valid: assert property (p_done_valid) else $error("result not shown");

endmodule

`default_nettype wire

// File: test/esa_tb_if.sv
// ----------------------------------------------------------------------------
// esa_tb_if
// testbench package with the predictor's statistics type; the rtl interfaces are used directly
// ----------------------------------------------------------------------------
`default_nettype none

package esa_tb_pkg;
  import esa_pkg::*;

  // statistics of one kind of difference on one channel
  typedef struct {
    logic [31:0] count;
    logic [30:0] peak;
    logic [30:0] avg;
    logic [63:0] sq_sum;
  } run_stats_t;
endpackage

`default_nettype wire

// File: test/error_statistics_accumulator_tb.sv
// ----------------------------------------------------------------------------
// error_statistics_accumulator_tb
// checks differences, threshold flags and per-channel running statistics
// against a predictor of the block, under random source gaps and sink stalls
// ----------------------------------------------------------------------------
`default_nettype none

module error_statistics_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import esa_pkg::*;
  import esa_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  esa_in_if  in_ch ();
  esa_out_if out_ch ();
  esa_cfg_if cfg_ch ();

  error_statistics_accumulator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // predictor state
  run_stats_t  abs_tab [Channels];
  run_stats_t  rel_tab [Channels];
  logic        sticky_flag;
  logic [30:0] abs_thresh;
  logic [30:0] rel_thresh;

  esa_out_t    expected_words [$];
  int          error_count;
  int          words_checked;
  int          words_sent;

  // sender burst state
  int          burst_left;

  // welford update of one running statistic
  function automatic void welford_update(ref run_stats_t s, input logic [30:0] x);
    logic [31:0] n;
    logic [63:0] d_old;
    logic [63:0] d_new;
    logic [63:0] prod;
    logic [31:0] new_avg;
    n = (s.count == 32'hffff_ffff) ? s.count : s.count + 32'd1;
    s.count = n;
    if (x > s.peak) begin
      s.peak = x;
    end
    if (x >= s.avg) begin
      d_old = 64'(x - s.avg);
      new_avg = 32'(s.avg) + 32'(d_old / 64'(n));
      d_new = 64'(32'(x) - new_avg);
    end else begin
      d_old = 64'(s.avg - x);
      new_avg = 32'(s.avg) - 32'(d_old / 64'(n));
      d_new = 64'(new_avg - 32'(x));
    end
    prod = d_old * d_new;
    if (s.sq_sum > 64'hffff_ffff_ffff_ffff - prod) begin
      s.sq_sum = 64'hffff_ffff_ffff_ffff;
    end else begin
      s.sq_sum = s.sq_sum + prod;
    end
    s.avg = new_avg[30:0];
  endfunction

  function automatic logic [30:0] sample_variance(run_stats_t s);
    logic [63:0] v;
    if (s.count < 32'd2) begin
      return '0;
    end
    v = (s.sq_sum / 64'(s.count - 32'd1)) >> 16;
    return (v > 64'(Max31)) ? Max31 : v[30:0];
  endfunction

  // works out the result word of one input word and advances the statistics
  function automatic esa_out_t predict_word(esa_in_t w);
    esa_out_t    r;
    logic signed [33:0] diff;
    logic [33:0] mag;
    logic [63:0] exp_mag;
    logic [63:0] quo;
    diff = 34'($signed(w.model_value)) - 34'($signed(w.expected_value));
    mag = diff[33] ? -diff : diff;
    r = '0;
    r.abs_difference = (mag > 34'(Max31)) ? Max31 : mag[30:0];
    r.rel_valid = (w.expected_value != '0);
    if (r.rel_valid) begin
      exp_mag = w.expected_value[31] ? 64'(-34'($signed(w.expected_value)))
                                     : 64'(w.expected_value);
      quo = (64'(r.abs_difference) << 16) / exp_mag;
      r.rel_difference = (quo > 64'(Max31)) ? Max31 : quo[30:0];
    end
    r.abs_over = r.abs_difference > abs_thresh;
    r.rel_over = r.rel_valid && (r.rel_difference > rel_thresh);
    if (r.abs_over || r.rel_over) begin
      sticky_flag = 1'b1;
    end
    r.mismatch_seen = sticky_flag;
    if (32'(w.channel) < Channels) begin
      welford_update(abs_tab[w.channel], r.abs_difference);
      if (r.rel_valid) begin
        welford_update(rel_tab[w.channel], r.rel_difference);
      end
      r.abs_peak_out = abs_tab[w.channel].peak;
      r.abs_avg_out = abs_tab[w.channel].avg;
      r.abs_spread_out = sample_variance(abs_tab[w.channel]);
      r.rel_peak_out = rel_tab[w.channel].peak;
      r.rel_avg_out = rel_tab[w.channel].avg;
      r.rel_spread_out = sample_variance(rel_tab[w.channel]);
    end
    return r;
  endfunction

  // sends one input word, with bursty gaps, and queues its expectation
  // valid stays up into the next word of a burst and drops for a gap
  task automatic send_word(logic [3:0] ch, logic [31:0] mv, logic [31:0] ev);
    esa_in_t w;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    w.channel = ch;
    w.model_value = mv;
    w.expected_value = ev;
    in_ch.data <= w;
    in_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_words.push_back(predict_word(w));
    words_sent++;
    @(negedge clk_i);
  endtask

  // waits for every expected word, then for the block to settle
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [30:0] value);
    cfg_ch.data.index <= idx;
    cfg_ch.data.data <= {$urandom_range(0, 1) == 1, value};
    cfg_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    if (idx == RegAbsLimit) begin
      abs_thresh = value;
    end else begin
      rel_thresh = value;
    end
    @(negedge clk_i);
  endtask

  task automatic set_limits(logic [30:0] abs_val, logic [30:0] rel_val);
    drain_block();
    write_reg(RegAbsLimit, abs_val);
    write_reg(RegRelLimit, rel_val);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 131072)) - 65536);
      2: return ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      3: return '0;
      default: return 32'($signed($urandom_range(0, 33554432)) - 16777216);
    endcase
  endfunction

  // extremes of the fields, zero expected value, channels 0, 1, 7 and 15
  task automatic test_directed();
    send_word(4'd0, 32'h0000_0000, 32'h0000_0000);
    send_word(4'd0, 32'h7fff_ffff, 32'h8000_0000);
    send_word(4'd0, 32'h8000_0000, 32'h7fff_ffff);
    send_word(4'd0, 32'h0001_0000, 32'h0000_0001);
    send_word(4'd1, 32'h0001_8000, 32'h0001_0000);
    send_word(4'd1, 32'h0000_8000, 32'h0001_0000);
    send_word(4'd1, 32'h1234_5678, 32'h0000_0000);
    send_word(4'd1, 32'hffff_0000, 32'hffff_ffff);
    send_word(4'd15, 32'hffff_ffff, 32'h0000_0001);
    send_word(4'd15, 32'h8000_0000, 32'h8000_0000);
    send_word(4'd15, 32'h5555_5555, 32'haaaa_aaaa);
    send_word(4'd7, 32'haaaa_aaaa, 32'h5555_5555);
    send_word(4'd7, 32'h0000_0000, 32'h8000_0000);
  endtask

  // random words on a few hot channels so statistics build up deep
  task automatic test_random(int words);
    logic [3:0] ch;
    for (int i = 0; i < words; i++) begin
      ch = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 3));
      send_word(ch, rand_value(), rand_value());
    end
  endtask

  // sink stalls in runs of random length, with stall-free stretches
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 15) == 0) begin
        out_ch.ready <= ($urandom_range(0, 2) != 0) ? 1'b0 : 1'b1;
        repeat ($urandom_range(1, 300)) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // result checker, field by field against the oldest expectation
  initial begin
    esa_out_t exp_w;
    esa_out_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_words.size() == 0) begin
          $display("%t: unexpected result word %h", $realtime, got);
          error_count++;
        end else begin
          exp_w = expected_words.pop_front();
          words_checked++;
          if (got.abs_difference !== exp_w.abs_difference)
            $display("%t: abs_difference exp %h got %h", $realtime, exp_w.abs_difference, got.abs_difference);
          if (got.rel_difference !== exp_w.rel_difference)
            $display("%t: rel_difference exp %h got %h", $realtime, exp_w.rel_difference, got.rel_difference);
          if (got.rel_valid !== exp_w.rel_valid)
            $display("%t: rel_valid exp %b got %b", $realtime, exp_w.rel_valid, got.rel_valid);
          if (got.abs_over !== exp_w.abs_over)
            $display("%t: abs_over exp %b got %b", $realtime, exp_w.abs_over, got.abs_over);
          if (got.rel_over !== exp_w.rel_over)
            $display("%t: rel_over exp %b got %b", $realtime, exp_w.rel_over, got.rel_over);
          if (got.mismatch_seen !== exp_w.mismatch_seen)
            $display("%t: mismatch_seen exp %b got %b", $realtime, exp_w.mismatch_seen, got.mismatch_seen);
          if (got.abs_peak_out !== exp_w.abs_peak_out)
            $display("%t: abs_peak_out exp %h got %h", $realtime, exp_w.abs_peak_out, got.abs_peak_out);
          if (got.abs_avg_out !== exp_w.abs_avg_out)
            $display("%t: abs_avg_out exp %h got %h", $realtime, exp_w.abs_avg_out, got.abs_avg_out);
          if (got.abs_spread_out !== exp_w.abs_spread_out)
            $display("%t: abs_spread_out exp %h got %h", $realtime, exp_w.abs_spread_out, got.abs_spread_out);
          if (got.rel_peak_out !== exp_w.rel_peak_out)
            $display("%t: rel_peak_out exp %h got %h", $realtime, exp_w.rel_peak_out, got.rel_peak_out);
          if (got.rel_avg_out !== exp_w.rel_avg_out)
            $display("%t: rel_avg_out exp %h got %h", $realtime, exp_w.rel_avg_out, got.rel_avg_out);
          if (got.rel_spread_out !== exp_w.rel_spread_out)
            $display("%t: rel_spread_out exp %h got %h", $realtime, exp_w.rel_spread_out, got.rel_spread_out);
          if (got !== exp_w) begin
            error_count++;
          end
        end
      end
    end
  end

  // hard stop on a hung block
  initial begin
    #2_000_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    error_count = 0;
    words_checked = 0;
    words_sent = 0;
    burst_left = 0;
    sticky_flag = 1'b0;
    abs_thresh = '0;
    rel_thresh = '0;
    for (int c = 0; c < Channels; c++) begin
      abs_tab[c] = '{default: '0};
      rel_tab[c] = '{default: '0};
    end
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset limits of zero flag nearly every word
    test_directed();
    set_limits(Max31, Max31);
    test_directed();
    test_random(200);
    set_limits(31'h0001_0000, 31'h0000_8000);
    test_random(250);
    set_limits(31'($urandom()), 31'($urandom()));
    test_random(200);
    set_limits('0, '0);
    test_random(174);
    drain_block();

    $display("covered %0d words, %0d results checked, four threshold settings",
             words_sent, words_checked);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/esa_pkg.sv
rtl/esa_if.sv
rtl/esa_div.sv
rtl/esa_datapath.sv
rtl/esa_ctrl.sv
rtl/error_statistics_accumulator.sv
test/esa_tb_if.sv
test/error_statistics_accumulator_tb.sv
